// ----- rtl/rof_pkg.sv -----
// ----------------------------------------------------------------------------
// rof_pkg
// Shared types and constants of the ray occlusion finder.
// ----------------------------------------------------------------------------
package rof_pkg;

  localparam int HEIGHT_BITS = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic clear_set;  // empty the store for the next set
    logic rd_en;      // read the point store
    logic rd_sel_k;   // read address is k (else j)
    logic latch_k;    // capture the point under test
    logic j_clear;    // restart the inner index
    logic j_inc;      // advance the inner index
    logic mul;        // register the cross-product terms
    logic cmp;        // evaluate one occluder candidate
    logic mark;       // write the hidden bit of point k, advance k
    logic sel_start;  // start a selection pass
    logic sel_cmp;    // compare one hidden point against the best so far
    logic out_load;   // load the output register from the best point
    logic emit;       // output transaction done
  } rof_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic k_done;
    logic j_done;
    logic j_hidden;
    logic best_found;
  } rof_sts_t;

endpackage

// ----- rtl/rof_ctrl.sv -----
// ----------------------------------------------------------------------------
// rof_ctrl
// Sequencer: loading, pairwise occlusion marking, sorted emission.
// ----------------------------------------------------------------------------
module rof_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              is_final,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rof_pkg::rof_sts_t sts,
  output rof_pkg::rof_cmd_t cmd
);
  import rof_pkg::*;

  typedef enum logic [10:0] {
    S_LOAD = 11'b000_0000_0001,
    S_KRD  = 11'b000_0000_0010,
    S_KLAT = 11'b000_0000_0100,
    S_JRD  = 11'b000_0000_1000,
    S_JMUL = 11'b000_0001_0000,
    S_JCMP = 11'b000_0010_0000,
    S_KEND = 11'b000_0100_0000,
    S_SRD  = 11'b000_1000_0000,
    S_SCMP = 11'b001_0000_0000,
    S_SEND = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_OUT);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_LOAD: begin
        cmd.accept = in_valid;
        if (in_valid && is_final) begin
          state_next = S_KRD;
        end
      end
      S_KRD: begin
        if (sts.k_done) begin
          cmd.sel_start = 1'b1;
          state_next    = S_SRD;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel_k = 1'b1;
          state_next   = S_KLAT;
        end
      end
      S_KLAT: begin
        cmd.latch_k = 1'b1;
        cmd.j_clear = 1'b1;
        state_next  = S_JRD;
      end
      S_JRD: begin
        if (sts.j_done) begin
          state_next = S_KEND;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_JMUL;
        end
      end
      S_JMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_JCMP;
      end
      S_JCMP: begin
        cmd.cmp    = 1'b1;
        cmd.j_inc  = 1'b1;
        state_next = S_JRD;
      end
      S_KEND: begin
        cmd.mark   = 1'b1;
        state_next = S_KRD;
      end
      S_SRD: begin
        if (sts.j_done) begin
          state_next = S_SEND;
        end else if (sts.j_hidden) begin
          cmd.rd_en  = 1'b1;
          state_next = S_SCMP;
        end else begin
          cmd.j_inc = 1'b1;
        end
      end
      S_SCMP: begin
        cmd.sel_cmp = 1'b1;
        cmd.j_inc   = 1'b1;
        state_next  = S_SRD;
      end
      S_SEND: begin
        if (sts.best_found) begin
          cmd.out_load = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.clear_set = 1'b1;
          state_next    = S_LOAD;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.emit      = 1'b1;
          cmd.sel_start = 1'b1;
          state_next    = S_SRD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Loading and emission never overlap
  a_one_side: assert property (@(posedge clk) disable iff (rst) !in_stall |-> !out_valid)
    else $error("input taken while a result is shown");

  // A result is only shown after the output register was loaded
  a_out_after_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result shown without a load");

  // A final point always leaves the load state
  a_final_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD && in_valid && is_final) |=> in_stall)
    else $error("final point did not start processing");

endmodule

// ----- rtl/rof_dp.sv -----
// ----------------------------------------------------------------------------
// rof_dp
// Point store, occlusion test and sorted selection of hidden points.
// ----------------------------------------------------------------------------
module rof_dp #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rof_pkg::rof_cmd_t                    cmd,
  output rof_pkg::rof_sts_t                    sts,
  input  logic signed [COORD_BITS-1:0]         point_x,
  input  logic signed [COORD_BITS-1:0]         point_y,
  input  logic signed [rof_pkg::HEIGHT_BITS-1:0] height,
  output logic signed [COORD_BITS-1:0]         hidden_x,
  output logic signed [COORD_BITS-1:0]         hidden_y,
  output logic                                 end_of_run,
  output logic                                 overflowed
);
  import rof_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 2 * COORD_BITS;
  localparam int MW = COORD_BITS + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

  // Point store
  logic signed [COORD_BITS-1:0]  mem_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0]  mem_y [MAX_POINTS];
  logic signed [HEIGHT_BITS-1:0] mem_h [MAX_POINTS];
  logic signed [COORD_BITS-1:0]  rd_x, rd_y;
  logic signed [HEIGHT_BITS-1:0] rd_h;

  // Control registers
  logic [CW-1:0]         count, k, j, total, emitted;
  logic                  ovf;
  logic [MAX_POINTS-1:0] hidden;
  logic                  occl;
  logic                  have_last, best_found;

  // Payload registers
  logic signed [COORD_BITS-1:0]  kx, ky;
  logic signed [HEIGHT_BITS-1:0] kh;
  logic signed [PW-1:0]          p1, p2;
  logic signed [COORD_BITS-1:0]  last_x, last_y, best_x, best_y;
  logic [CW-1:0]                 last_i, best_i;

  logic              origin, full, wr_en;
  logic [IW-1:0]     rd_addr;
  logic [MW-1:0]     mag_k, mag_j;
  logic              same_ray, nearer, occ_hit;
  logic              above_last, below_best;

  function automatic logic upper(input logic signed [COORD_BITS-1:0] x,
                                 input logic signed [COORD_BITS-1:0] y);
    logic r;
    r = (x == '0) ? (y > 0) : (x > 0);
    return r;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [COORD_BITS-1:0] x,
                                        input logic signed [COORD_BITS-1:0] y);
    logic [COORD_BITS-1:0] ax, ay;
    ax = x[COORD_BITS-1] ? COORD_BITS'(-x) : COORD_BITS'(x);
    ay = y[COORD_BITS-1] ? COORD_BITS'(-y) : COORD_BITS'(y);
    return {1'b0, ax} + {1'b0, ay};
  endfunction

  // (ax, ay, ai) strictly before (bx, by, bi)
  function automatic logic key_less(input logic signed [COORD_BITS-1:0] ax,
                                    input logic signed [COORD_BITS-1:0] ay,
                                    input logic [CW-1:0] ai,
                                    input logic signed [COORD_BITS-1:0] bx,
                                    input logic signed [COORD_BITS-1:0] by,
                                    input logic [CW-1:0] bi);
    logic r;
    if (ax != bx)      r = ax < bx;
    else if (ay != by) r = ay < by;
    else               r = ai < bi;
    return r;
  endfunction

  assign origin  = (point_x == '0) && (point_y == '0);
  assign full    = (count == MAX_CNT);
  assign wr_en   = cmd.accept && !origin && !full;
  assign rd_addr = cmd.rd_sel_k ? k[IW-1:0] : j[IW-1:0];

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[count[IW-1:0]] <= point_x;
      mem_y[count[IW-1:0]] <= point_y;
      mem_h[count[IW-1:0]] <= height;
    end
    if (cmd.rd_en) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
      rd_h <= mem_h[rd_addr];
    end
  end

  // Occluder test: j on the ray of k, nearer (or same spot, earlier), not lower
  assign mag_k    = mag(kx, ky);
  assign mag_j    = mag(rd_x, rd_y);
  assign same_ray = (upper(kx, ky) == upper(rd_x, rd_y)) && (p1 == p2);
  assign nearer   = (mag_j < mag_k) || ((mag_j == mag_k) && (j < k));
  assign occ_hit  = (j != k) && same_ray && nearer && (rd_h >= kh);

  // Selection: smallest key above the last one emitted
  assign above_last = !have_last || key_less(last_x, last_y, last_i, rd_x, rd_y, j);
  assign below_best = !best_found || key_less(rd_x, rd_y, j, best_x, best_y, best_i);

  // Point under test and cross-product terms
  always_ff @(posedge clk) begin
    if (cmd.latch_k) begin
      kx <= rd_x;
      ky <= rd_y;
      kh <= rd_h;
    end
    if (cmd.mul) begin
      p1 <= PW'(kx) * PW'(rd_y);
      p2 <= PW'(ky) * PW'(rd_x);
    end
    if (cmd.sel_cmp && above_last && below_best) begin
      best_x <= rd_x;
      best_y <= rd_y;
      best_i <= j;
    end
    if (cmd.out_load) begin
      last_x     <= best_x;
      last_y     <= best_y;
      last_i     <= best_i;
      hidden_x   <= best_x;
      hidden_y   <= best_y;
      end_of_run <= (emitted + 1'b1) == total;
      overflowed <= ovf;
    end
  end

  // Counters and flags
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_set) begin
      count      <= '0;
      ovf        <= 1'b0;
      k          <= '0;
      j          <= '0;
      total      <= '0;
      emitted    <= '0;
      hidden     <= '0;
      occl       <= 1'b0;
      have_last  <= 1'b0;
      best_found <= 1'b0;
    end else begin
      if (wr_en) begin
        count <= count + 1'b1;
      end
      if (cmd.accept && !origin && full) begin
        ovf <= 1'b1;
      end
      if (cmd.j_clear || cmd.sel_start) begin
        j <= '0;
      end else if (cmd.j_inc) begin
        j <= j + 1'b1;
      end
      if (cmd.latch_k) begin
        occl <= 1'b0;
      end else if (cmd.cmp && occ_hit) begin
        occl <= 1'b1;
      end
      if (cmd.mark) begin
        hidden[k[IW-1:0]] <= occl;
        total             <= total + CW'(occl);
        k                 <= k + 1'b1;
      end
      if (cmd.sel_start) begin
        best_found <= 1'b0;
      end else if (cmd.sel_cmp && above_last && below_best) begin
        best_found <= 1'b1;
      end
      if (cmd.out_load) begin
        have_last <= 1'b1;
      end
      if (cmd.emit) begin
        emitted <= emitted + 1'b1;
      end
    end
  end

  assign sts.k_done     = (k == count);
  assign sts.j_done     = (j == count);
  assign sts.j_hidden   = hidden[j[IW-1:0]];
  assign sts.best_found = best_found;

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= MAX_CNT)
    else $error("point count beyond store size");

  a_emit_range: assert property (@(posedge clk) disable iff (rst) emitted <= total)
    else $error("more results than hidden points");

  a_load_found: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (best_found && emitted < total))
    else $error("output loaded without a selected point");

endmodule

// ----- rtl/ray_occlusion_finder_top.sv -----
// ----------------------------------------------------------------------------
// ray_occlusion_finder_top
// Finds points hidden behind nearer points, at least as tall, on the same ray.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one point per transaction,
//   one per cycle while loading. The point marked is_final starts the work;
//   in_stall stays high until every result of the set has been taken.
//   Points at the origin are ignored; points past MAX_POINTS are dropped
//   and the results of that set carry overflowed.
//   Marking reads each stored point k, then for every stored point j
//   reads j, registers the cross-product terms and compares, through the
//   single store read port. Each result then costs one selection pass
//   over the store before it is shown.
//   Output channel (out_valid / out_stall): results come ordered by x then
//   y, end_of_run on the last one; a set with nothing hidden gives none.
//   A stalled result holds until taken. Reset empties the store and makes
//   the block ready for a new set at once.
// ----------------------------------------------------------------------------
module ray_occlusion_finder_top #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_BITS-1:0]           point_x,
  input  logic signed [COORD_BITS-1:0]           point_y,
  input  logic signed [rof_pkg::HEIGHT_BITS-1:0] height,
  input  logic                                   is_final,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [COORD_BITS-1:0]           hidden_x,
  output logic signed [COORD_BITS-1:0]           hidden_y,
  output logic                                   end_of_run,
  output logic                                   overflowed
);
  import rof_pkg::*;

  rof_cmd_t cmd;
  rof_sts_t sts;

  // Sequencer
  rof_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .is_final  (is_final),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Store and arithmetic
  rof_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .point_x    (point_x),
    .point_y    (point_y),
    .height     (height),
    .hidden_x   (hidden_x),
    .hidden_y   (hidden_y),
    .end_of_run (end_of_run),
    .overflowed (overflowed)
  );

endmodule
